/* design/ps2asc_pkg.sv */
package ps2asc_pkg;

  // Queue storage and pointer sizing
  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // Scancode constants
  localparam int          KEYMAP_LEN  = 84;
  localparam int          KEY_N       = 128;
  localparam logic [6:0]  KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0]  KEY_RSHIFT  = 7'h36;
  localparam logic [6:0]  KEY_CTRL    = 7'h1D;
  localparam logic [6:0]  KEY_CAPS    = 7'h3A;
  localparam logic [7:0]  CHAR_LOW_C  = 8'h63;
  localparam logic [7:0]  CHAR_UP_C   = 8'h43;
  localparam logic [7:0]  CHAR_ETX    = 8'h03;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_SCAN      = 2'd0,
    REQ_POP_ASCII = 2'd1,
    REQ_POP_RAW   = 2'd2,
    REQ_NONE      = 2'd3
  } req_t;

  // Classified request handed from the front end to the FIFO back end
  typedef struct packed {
    req_t       op;
    logic [7:0] scan_byte;
    logic       push_ascii;
    logic [7:0] ascii_char;
  } cmd_t;

  // US layout, unshifted
  localparam logic [7:0] KEYMAP_PLAIN [KEYMAP_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  // US layout, shifted
  localparam logic [7:0] KEYMAP_UPPER [KEYMAP_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  // Advance a FIFO pointer with wrap at the queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

endpackage

/* design/ps2asc_front.sv */
module ps2asc_front
  import ps2asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req_type,
  input  logic [7:0] scan_byte,
  output cmd_t       cmd
);

  logic [KEY_N-1:0] held_r;
  logic             shift_r, shift_nxt;
  logic             ctrl_r, ctrl_nxt;
  logic             caps_r, caps_nxt;
  logic             accept;
  logic [6:0]       key;
  logic [7:0]       ch;
  logic             push;

  assign accept = req_valid && req_ready;
  assign key    = scan_byte[6:0];

  // Classify the request and decode a press into a character
  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    caps_nxt  = caps_r;
    ch        = '0;
    push      = 1'b0;
    if (req_type == REQ_SCAN) begin
      if (scan_byte[7]) begin
        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
          shift_nxt = 1'b0;
        end
        if (key == KEY_CTRL) begin
          ctrl_nxt = 1'b0;
        end
      end else if (!held_r[key]) begin
        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
          shift_nxt = 1'b1;
        end else if (key == KEY_CTRL) begin
          ctrl_nxt = 1'b1;
        end else if (key == KEY_CAPS) begin
          caps_nxt = !caps_r;
        end else if (scan_byte < 8'(KEYMAP_LEN)) begin
          if (shift_r ^ caps_r) begin
            ch = KEYMAP_UPPER[key];
          end else begin
            ch = KEYMAP_PLAIN[key];
          end
          if (ctrl_r && (ch == CHAR_LOW_C || ch == CHAR_UP_C)) begin
            ch = CHAR_ETX;
          end
          push = (ch != '0);
        end
      end
    end
  end

  // Hold key and modifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      caps_r  <= 1'b0;
    end else if (accept) begin
      if (req_type == REQ_SCAN) begin
        held_r[key] <= !scan_byte[7];
      end
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      caps_r  <= caps_nxt;
    end
  end

  assign cmd.op         = req_type;
  assign cmd.scan_byte  = scan_byte;
  assign cmd.push_ascii = push;
  assign cmd.ascii_char = ch;

endmodule

/* design/ps2asc_cmdq.sv */
module ps2asc_cmdq
  import ps2asc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slot_r [2];
  logic       wr_idx_r;
  logic       rd_idx_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_idx_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_idx_r] <= push_cmd;
    end
  end

  // Advance indexes and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_idx_r <= !wr_idx_r;
      end
      if (do_pop) begin
        rd_idx_r <= !rd_idx_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

/* design/ps2asc_back.sv */
module ps2asc_back
  import ps2asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       read_valid,
  output logic       ascii_waiting,
  output logic       scan_waiting
);

  logic [7:0]       ascii_mem [FIFO_DEPTH];
  logic [7:0]       raw_mem   [FIFO_DEPTH];
  logic [PTR_W-1:0] ascii_wr_r, ascii_wr_nxt;
  logic [PTR_W-1:0] ascii_rd_r, ascii_rd_nxt;
  logic [PTR_W-1:0] raw_wr_r, raw_wr_nxt;
  logic [PTR_W-1:0] raw_rd_r, raw_rd_nxt;
  logic             exec;
  logic             ascii_wen;
  logic             raw_wen;
  logic             rvalid_nxt;
  logic             out_valid_r;
  logic             rvalid_r;
  logic             src_ascii_r;
  logic             ascii_wait_r;
  logic             scan_wait_r;
  logic [7:0]       ascii_q_r;
  logic [7:0]       raw_q_r;

  assign exec      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = !out_valid_r || out_ready;

  // Carry out one request on the two FIFOs
  always_comb begin
    ascii_wr_nxt = ascii_wr_r;
    ascii_rd_nxt = ascii_rd_r;
    raw_wr_nxt   = raw_wr_r;
    raw_rd_nxt   = raw_rd_r;
    ascii_wen    = 1'b0;
    raw_wen      = 1'b0;
    rvalid_nxt   = 1'b0;
    case (cmd.op)
      REQ_SCAN: begin
        if (ptr_inc(raw_wr_r) != raw_rd_r) begin
          raw_wen    = 1'b1;
          raw_wr_nxt = ptr_inc(raw_wr_r);
        end
        if (cmd.push_ascii && (ptr_inc(ascii_wr_r) != ascii_rd_r)) begin
          ascii_wen    = 1'b1;
          ascii_wr_nxt = ptr_inc(ascii_wr_r);
        end
      end
      REQ_POP_ASCII: begin
        if (ascii_rd_r != ascii_wr_r) begin
          rvalid_nxt   = 1'b1;
          ascii_rd_nxt = ptr_inc(ascii_rd_r);
        end
      end
      REQ_POP_RAW: begin
        if (raw_rd_r != raw_wr_r) begin
          rvalid_nxt = 1'b1;
          raw_rd_nxt = ptr_inc(raw_rd_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Write and read the FIFO storage
  always_ff @(posedge clk) begin
    if (exec && ascii_wen) begin
      ascii_mem[ascii_wr_r] <= cmd.ascii_char;
    end
    if (exec && raw_wen) begin
      raw_mem[raw_wr_r] <= cmd.scan_byte;
    end
    if (exec) begin
      ascii_q_r   <= ascii_mem[ascii_rd_r];
      raw_q_r     <= raw_mem[raw_rd_r];
      src_ascii_r <= (cmd.op == REQ_POP_ASCII);
    end
  end

  // Update pointers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_wr_r   <= '0;
      ascii_rd_r   <= '0;
      raw_wr_r     <= '0;
      raw_rd_r     <= '0;
      out_valid_r  <= 1'b0;
      rvalid_r     <= 1'b0;
      ascii_wait_r <= 1'b0;
      scan_wait_r  <= 1'b0;
    end else begin
      if (exec) begin
        ascii_wr_r   <= ascii_wr_nxt;
        ascii_rd_r   <= ascii_rd_nxt;
        raw_wr_r     <= raw_wr_nxt;
        raw_rd_r     <= raw_rd_nxt;
        rvalid_r     <= rvalid_nxt;
        ascii_wait_r <= (ascii_rd_nxt != ascii_wr_nxt);
        scan_wait_r  <= (raw_rd_nxt != raw_wr_nxt);
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
        rvalid_r    <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign read_valid    = rvalid_r;
  assign ascii_waiting = ascii_wait_r;
  assign scan_waiting  = scan_wait_r;
  assign read_data     = !rvalid_r ? 8'h00 : (src_ascii_r ? ascii_q_r : raw_q_r);

`ifndef SYNTHESIS
  a_push_only_on_scan : assert property (@(posedge clk) disable iff (!rst_n)
    exec && cmd.op != REQ_SCAN |=> ascii_wr_r == $past(ascii_wr_r)
                                 && raw_wr_r == $past(raw_wr_r))
    else $error("FIFO write pointer moved on a pop request");

  a_pop_hits : assert property (@(posedge clk) disable iff (!rst_n)
    exec && cmd.op == REQ_POP_ASCII && ascii_rd_r != ascii_wr_r
      |=> rvalid_r && src_ascii_r && ascii_wait_r == (ascii_rd_r != ascii_wr_r))
    else $error("ASCII pop on a nonempty FIFO did not return an entry");

  a_valid_implies_out : assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> out_valid_r)
    else $error("read valid without a pending result");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(raw_rd_r) && $stable(ascii_rd_r))
    else $error("request executed while the result was stalled");
`endif

endmodule

/* design/ps2_scancode_to_ascii_fifo.sv */
// A request is registered in the command queue, then in the back end's result
// registers. One request per cycle is accepted while results are taken; the two-entry
// command queue lets the front end accept two more requests while a result waits to
// be taken, then it stalls. Reset (rst_n low, synchronous) clears held keys,
// shift/ctrl/caps and all FIFO pointers; FIFO storage is not cleared and needs no sweep.
module ps2_scancode_to_ascii_fifo
  import ps2asc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scan_byte
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] read_data
  output logic [2:0] out_tuser   // [0] read_valid, [1] ascii_waiting, [2] scan_waiting
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_ready;
  logic q_valid;
  logic back_ready;

  assign in_tready = q_ready;

  // Decode requests and track keyboard state
  ps2asc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (q_ready),
    .req_type  (req_t'(in_tuser)),
    .scan_byte (in_tdata),
    .cmd       (front_cmd)
  );

  // Decouple decode from FIFO execution
  ps2asc_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (q_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Run the ASCII and raw FIFOs
  ps2asc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd_ready     (back_ready),
    .cmd           (back_cmd),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .read_data     (out_tdata),
    .read_valid    (out_tuser[0]),
    .ascii_waiting (out_tuser[1]),
    .scan_waiting  (out_tuser[2])
  );

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2asc_pkg::*;

  localparam int QUEUE_CAP   = FIFO_DEPTH - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 150;
  localparam int DRAIN_POPS  = 40;
  localparam int MAX_PRINTS  = 40;

  // Scancode set 1, US layout, unshifted and shifted characters
  localparam logic [7:0] US_PLAIN [KEYMAP_LEN] = '{
    'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38,
    'h39, 'h30, 'h2D, 'h3D, 'h08, 'h09, 'h71, 'h77, 'h65, 'h72,
    'h74, 'h79, 'h75, 'h69, 'h6F, 'h70, 'h5B, 'h5D, 'h0A, 'h00,
    'h61, 'h73, 'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B,
    'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76, 'h62, 'h6E,
    'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h37, 'h38, 'h39, 'h2D, 'h34, 'h35, 'h36, 'h2B, 'h31,
    'h32, 'h33, 'h30, 'h2E
  };

  localparam logic [7:0] US_SHIFTED [KEYMAP_LEN] = '{
    'h00, 'h1B, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5E, 'h26, 'h2A,
    'h28, 'h29, 'h5F, 'h2B, 'h08, 'h09, 'h51, 'h57, 'h45, 'h52,
    'h54, 'h59, 'h55, 'h49, 'h4F, 'h50, 'h7B, 'h7D, 'h0A, 'h00,
    'h41, 'h53, 'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h3A,
    'h22, 'h7E, 'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56, 'h42, 'h4E,
    'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h37, 'h38, 'h39, 'h2D, 'h34, 'h35, 'h36, 'h2B, 'h31,
    'h32, 'h33, 'h30, 'h2E
  };

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       ascii_waiting;
    logic       scan_waiting;
  } kbd_read_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic [1:0] in_tuser   = REQ_NONE;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;

  // Keyboard state mirrored by the predictor
  bit         key_down [KEY_N];
  bit         shift_on;
  bit         ctrl_on;
  bit         caps_on;
  logic [7:0] ascii_fifo [$];
  logic [7:0] raw_fifo [$];
  kbd_read_t  expected_reads [$];

  int  sent_cnt;
  int  checked_cnt;
  int  error_cnt;
  int  ascii_drops;
  int  raw_drops;
  int  empty_pops;
  bit  no_gaps;
  bit  stall_hold;

  ps2_scancode_to_ascii_fifo u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1ms;
    $display("timeout: %0d requests still waiting for a result", expected_reads.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Apply one request to the mirrored state and return the read it produces
  function automatic kbd_read_t decode_request(input req_t req, input logic [7:0] code);
    kbd_read_t  res;
    logic [6:0] key;
    logic [7:0] ch;
    res = '0;
    key = code[6:0];
    case (req)
      REQ_SCAN: begin
        if (raw_fifo.size() < QUEUE_CAP) raw_fifo.push_back(code);
        else raw_drops++;
        if (code[7]) begin
          key_down[key] = 1'b0;
          if (key == KEY_LSHIFT || key == KEY_RSHIFT) shift_on = 1'b0;
          if (key == KEY_CTRL) ctrl_on = 1'b0;
        end else if (!key_down[key]) begin
          key_down[key] = 1'b1;
          if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
            shift_on = 1'b1;
          end else if (key == KEY_CTRL) begin
            ctrl_on = 1'b1;
          end else if (key == KEY_CAPS) begin
            caps_on = !caps_on;
          end else if (key < KEYMAP_LEN) begin
            ch = (shift_on ^ caps_on) ? US_SHIFTED[key] : US_PLAIN[key];
            if (ch != 8'h00) begin
              if (ctrl_on && (ch == CHAR_LOW_C || ch == CHAR_UP_C)) ch = CHAR_ETX;
              if (ascii_fifo.size() < QUEUE_CAP) ascii_fifo.push_back(ch);
              else ascii_drops++;
            end
          end
        end
      end
      REQ_POP_ASCII: begin
        if (ascii_fifo.size() != 0) begin
          res.data  = ascii_fifo.pop_front();
          res.valid = 1'b1;
        end else begin
          empty_pops++;
        end
      end
      REQ_POP_RAW: begin
        if (raw_fifo.size() != 0) begin
          res.data  = raw_fifo.pop_front();
          res.valid = 1'b1;
        end else begin
          empty_pops++;
        end
      end
      default: ;
    endcase
    res.ascii_waiting = (ascii_fifo.size() != 0);
    res.scan_waiting  = (raw_fifo.size() != 0);
    return res;
  endfunction

  task automatic check_read();
    kbd_read_t want;
    if (expected_reads.size() == 0) begin
      flag_mismatch($sformatf("result %02h/%03b with no request pending", out_tdata, out_tuser));
      return;
    end
    want = expected_reads.pop_front();
    if (out_tdata !== want.data)
      flag_mismatch($sformatf("read_data got %02h want %02h", out_tdata, want.data));
    if (out_tuser[0] !== want.valid)
      flag_mismatch($sformatf("read_valid got %b want %b", out_tuser[0], want.valid));
    if (out_tuser[1] !== want.ascii_waiting)
      flag_mismatch($sformatf("ascii_waiting got %b want %b", out_tuser[1], want.ascii_waiting));
    if (out_tuser[2] !== want.scan_waiting)
      flag_mismatch($sformatf("scan_waiting got %b want %b", out_tuser[2], want.scan_waiting));
    checked_cnt++;
  endtask

  // Predict on every accepted request, then check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_reads.push_back(decode_request(req_t'(in_tuser), in_tdata));
      end
      if (out_tvalid && out_tready) begin
        check_read();
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive out_tready: random stalls, or one long hold-off when asked
  initial begin : ready_gen
    int gap;
    int hold_cnt;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_hold) begin
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        stall_hold = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input req_t req, input logic [7:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
  endtask

  task automatic tap_key(input logic [6:0] key);
    send_req(REQ_SCAN, {1'b0, key});
    send_req(REQ_SCAN, {1'b1, key});
  endtask

  // Empty pops, the unused request kind and a scan byte riding on a pop
  task automatic test_idle_requests();
    send_req(REQ_POP_ASCII, 8'hFF);
    send_req(REQ_POP_RAW, 8'h1E);
    send_req(REQ_NONE, 8'hFF);
  endtask

  // Shift, caps lock, both together, and ctrl with c
  task automatic test_modifiers();
    send_req(REQ_SCAN, {1'b0, KEY_LSHIFT});
    tap_key(7'h1E);
    send_req(REQ_SCAN, {1'b1, KEY_LSHIFT});
    send_req(REQ_SCAN, {1'b0, KEY_CAPS});
    tap_key(7'h02);
    send_req(REQ_SCAN, {1'b0, KEY_RSHIFT});
    tap_key(7'h02);
    send_req(REQ_SCAN, {1'b1, KEY_RSHIFT});
    send_req(REQ_SCAN, {1'b1, KEY_CAPS});
    send_req(REQ_SCAN, {1'b0, KEY_CTRL});
    tap_key(7'h2E);
    send_req(REQ_SCAN, {1'b1, KEY_CTRL});
  endtask

  // Field extremes, codes past the table and a repeated press
  task automatic test_edges();
    send_req(REQ_SCAN, 8'h00);
    send_req(REQ_SCAN, 8'h7F);
    send_req(REQ_SCAN, 8'hFF);
    send_req(REQ_SCAN, 8'h1E);
    send_req(REQ_SCAN, 8'h1E);
    send_req(REQ_POP_ASCII, 8'h00);
    send_req(REQ_POP_RAW, 8'hFF);
  endtask

  // Overfill both queues, then pop part of each back out
  task automatic test_queue_full();
    int i;
    no_gaps = 1'b1;
    for (i = 0; i < QUEUE_CAP + 5; i++) tap_key(7'h10 + 7'(i % 10));
    no_gaps = 1'b0;
    for (i = 0; i < DRAIN_POPS; i++) send_req(REQ_POP_ASCII, 8'(i));
    for (i = 0; i < DRAIN_POPS; i++) send_req(REQ_POP_RAW, 8'(i));
  endtask

  // Hold the result side off while requests keep coming
  task automatic test_backpressure();
    int i;
    stall_hold = 1'b1;
    no_gaps = 1'b1;
    for (i = 0; i < 24; i++) tap_key(7'($urandom_range(1, KEYMAP_LEN - 1)));
    no_gaps = 1'b0;
    for (i = 0; i < 30; i++) send_req(req_t'(2'($urandom_range(1, 2))), 8'($urandom));
  endtask

  // One keystroke, optionally wrapped in shift, ctrl or a caps toggle
  task automatic type_key();
    logic [6:0] key;
    logic [6:0] shift_key;
    bit         with_shift;
    bit         with_ctrl;
    key        = 7'($urandom_range(1, KEYMAP_LEN - 1));
    shift_key  = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
    with_shift = ($urandom_range(0, 3) == 0);
    with_ctrl  = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 15) == 0) tap_key(KEY_CAPS);
    if (with_ctrl) send_req(REQ_SCAN, {1'b0, KEY_CTRL});
    if (with_shift) send_req(REQ_SCAN, {1'b0, shift_key});
    send_req(REQ_SCAN, {1'b0, key});
    if ($urandom_range(0, 7) == 0) send_req(REQ_SCAN, {1'b0, key});
    send_req(REQ_SCAN, {1'b1, key});
    if (with_shift) send_req(REQ_SCAN, {1'b1, shift_key});
    if (with_ctrl) send_req(REQ_SCAN, {1'b1, KEY_CTRL});
  endtask

  // Mostly clean typing and pop bursts, some raw noise
  task automatic test_random_typing();
    int stop_at;
    int pick;
    int n;
    stop_at = sent_cnt + RAND_ITEMS;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        type_key();
      end else if (pick < 60) begin
        for (n = $urandom_range(1, 3); n > 0; n--) send_req(REQ_POP_ASCII, 8'($urandom));
      end else if (pick < 85) begin
        for (n = $urandom_range(1, 6); n > 0; n--) send_req(REQ_POP_RAW, 8'($urandom));
      end else begin
        send_req(req_t'(2'($urandom_range(0, 3))), 8'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_requests();
    test_modifiers();
    test_edges();
    test_queue_full();
    test_backpressure();
    test_random_typing();

    in_tvalid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d pops on an empty queue",
             sent_cnt, checked_cnt, empty_pops);
    $display("full-queue drops: %0d ascii, %0d raw; %0d mismatches",
             ascii_drops, raw_drops, error_cnt);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ps2asc_pkg.sv
design/ps2asc_front.sv
design/ps2asc_cmdq.sv
design/ps2asc_back.sv
design/ps2_scancode_to_ascii_fifo.sv
test/tb.sv
